### rtl/ajb_pkg.sv
// Shared types, codes and constants of the audio playback jitter buffer.
package ajb_pkg;

    localparam int DEF_RING_DEPTH = 65536;
    localparam int DEF_CHUNK_LEN  = 64;
    localparam int DIVW           = 7;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_FEED  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;
    localparam logic [1:0] REQ_PULL  = 2'd3;

    localparam logic [2:0] KIND_IDLE  = 3'd0;
    localparam logic [2:0] KIND_PREBUF = 3'd1;
    localparam logic [2:0] KIND_SAMPLE = 3'd2;
    localparam logic [2:0] KIND_UNDER = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam logic [1:0] CFG_VOLUME  = 2'd0;
    localparam logic [1:0] CFG_MIN_PRE = 2'd1;
    localparam logic [1:0] CFG_MAX_PRE = 2'd2;

    localparam logic [15:0] VOLUME_RST  = 16'd32768;
    localparam logic [15:0] MIN_PRE_RST = 16'd6400;
    localparam logic [15:0] MAX_PRE_RST = 16'd32000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [23:0] expected_bytes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] sample;
        logic               last;
        logic [15:0]        level;
        logic [15:0]        underruns;
        logic [15:0]        prebuffered;
    } out_item_t;

    typedef struct packed {
        logic        is_start;
        logic        is_feed;
        logic        is_end;
        logic        is_pull;
        logic [7:0]  data_byte;
        logic [23:0] expected_bytes;
    } cmd_t;

    typedef struct packed {
        logic [15:0] volume;
        logic [15:0] min_pre;
        logic [15:0] max_pre;
    } cfg_t;

endpackage

### rtl/ajb_front.sv
// Request intake: classify each request and hold it in a two-entry queue.
module ajb_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ajb_pkg::in_item_t in_data,
    output logic            cmd_valid,
    output ajb_pkg::cmd_t   cmd,
    input  logic            cmd_pop
);
    import ajb_pkg::*;

    cmd_t        q_reg [2];
    logic        rd_reg, rd_next;
    logic        wr_reg, wr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        cls;
    logic        push;

    always_comb
    begin
        cls                = '0;
        cls.data_byte      = in_data.data_byte;
        cls.expected_bytes = in_data.expected_bytes;
        case (in_data.req_type)
            REQ_START: cls.is_start = 1'b1;
            REQ_FEED:  cls.is_feed  = 1'b1;
            REQ_END:   cls.is_end   = 1'b1;
            default:   cls.is_pull  = 1'b1;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ cmd_pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/ajb_back.sv
// Request execution: byte ring, speech state, chunk playback and level tracking.
module ajb_back
#(
    parameter int RING_DEPTH = ajb_pkg::DEF_RING_DEPTH,
    parameter int CHUNK_LEN  = ajb_pkg::DEF_CHUNK_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ajb_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    input  ajb_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output ajb_pkg::out_item_t out_data
);
    import ajb_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int NBW = $clog2(2 * CHUNK_LEN + 1);
    localparam int CW  = ((AW > NBW) ? AW : NBW) + 1;
    localparam int SW  = $clog2(CHUNK_LEN) + 31;
    localparam int DCW = $clog2(SW + 1);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [CW-1:0] CHUNK_BYTES = CW'(2 * CHUNK_LEN);
    localparam logic [39:0] TENTH_MUL = 40'd838861;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_HI   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_LVL  = 3'd7;

    logic [7:0]  ring_mem [RING_DEPTH];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] raddr;

    logic [2:0]    state_reg;
    logic [AW-1:0] wp_reg, rp_reg, ptr_reg, start_reg;
    logic          speaking_reg, ended_reg, started_reg;
    logic [23:0]   expected_reg;
    logic [15:0]   under_reg, prebuf_reg, level_reg;
    logic          pass2_reg, div_lvl_reg;
    logic [DIVW-1:0] nsamp_reg, cnt_reg, divisor_reg;
    logic [7:0]    lo_reg;
    logic signed [33:0] prod_reg;
    logic [SW-1:0] sum_reg, dq_reg;
    logic [DIVW-1:0] drem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [33:0]   rad_reg;
    logic [16:0]   root_reg;
    logic [18:0]   srem_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;

    logic [AW:0]   held;
    logic [AW-1:0] avail;
    logic          full, out_free;
    logic [23:0]   want;
    logic          wait_pb;
    logic [CW-1:0] nbytes;
    logic [DIVW-1:0] nsamp;
    logic [AW:0]   rp_sum;
    logic [15:0]   pre_sat, pre_next, under_inc;
    logic [AW-1:0] wp_inc, ptr_inc;
    logic signed [15:0] samp;
    logic signed [16:0] ma, mb;
    logic signed [33:0] adj, shv;
    logic signed [15:0] scaled;
    logic [DIVW:0] dt;
    logic          dge;
    logic [20:0]   st, strial;
    logic          sge;
    logic [19:0]   lvl_num;
    logic [39:0]   lvl_prod;
    logic [16:0]   lvl_quo;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return ({1'b0, p} + 1'b1 == DEPTH_W) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        held = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                                  : ({1'b0, wp_reg} + DEPTH_W - {1'b0, rp_reg});
        avail = held[AW-1:0];
        full  = (held >= DEPTH_W - 1'b1);
        out_free = !out_valid_reg || out_ready;
        if (expected_reg == 24'd0)
            want = {8'd0, cfg.min_pre};
        else if (expected_reg < {8'd0, cfg.max_pre})
            want = expected_reg;
        else
            want = {8'd0, cfg.max_pre};
        wait_pb = !started_reg && (25'(avail) < {1'b0, want}) && !ended_reg;
        nbytes  = (CW'(avail) < CHUNK_BYTES) ? CW'(avail) : CHUNK_BYTES;
        nsamp   = DIVW'(nbytes >> 1);
        rp_sum  = {1'b0, rp_reg} + (AW+1)'(nbytes);
        if (rp_sum >= DEPTH_W)
            rp_sum = rp_sum - DEPTH_W;
        pre_sat  = ((AW+1)'(avail) > (AW+1)'(16'hFFFF)) ? 16'hFFFF : 16'(avail);
        pre_next = started_reg ? prebuf_reg : pre_sat;
        under_inc = under_reg + {15'd0, (under_reg != 16'hFFFF)};
        wp_inc  = nxt(wp_reg);
        ptr_inc = nxt(ptr_reg);
        raddr   = ptr_reg;
        samp    = {rdata_reg, lo_reg};
        ma      = {samp[15], samp};
        mb      = pass2_reg ? $signed({1'b0, cfg.volume}) : ma;
        adj     = prod_reg + ((prod_reg < 0) ? 34'sd32767 : 34'sd0);
        shv     = adj >>> 15;
        if (shv > 34'sd32767)
            scaled = 16'sh7FFF;
        else if (shv < -34'sd32768)
            scaled = -16'sd32768;
        else
            scaled = shv[15:0];
        dt      = {drem_reg, dq_reg[SW-1]};
        dge     = (dt >= {1'b0, divisor_reg});
        st      = {srem_reg, rad_reg[33:32]};
        strial  = {2'b00, root_reg, 2'b01};
        sge     = (st >= strial);
        lvl_num = 20'(level_reg) * 20'd6 + 20'(root_reg) * 20'd4;
        lvl_prod = {20'd0, dq_reg[19:0]} * TENTH_MUL;
        lvl_quo  = lvl_prod[39:23];
    end

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid &&
                       (!cmd.is_pull || out_free);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= ring_mem[raddr];
        if (state_reg == S_IDLE && cmd_valid && cmd.is_feed && speaking_reg && !full)
        begin
            ring_mem[wp_reg] <= cmd.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HI)
            lo_reg <= rdata_reg;
        if (state_reg == S_MUL)
            prod_reg <= ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            ptr_reg       <= '0;
            start_reg     <= '0;
            speaking_reg  <= 1'b0;
            ended_reg     <= 1'b0;
            started_reg   <= 1'b0;
            expected_reg  <= '0;
            under_reg     <= '0;
            prebuf_reg    <= '0;
            level_reg     <= '0;
            pass2_reg     <= 1'b0;
            div_lvl_reg   <= 1'b0;
            nsamp_reg     <= '0;
            cnt_reg       <= '0;
            divisor_reg   <= '0;
            sum_reg       <= '0;
            dq_reg        <= '0;
            drem_reg      <= '0;
            dcnt_reg      <= '0;
            rad_reg       <= '0;
            root_reg      <= '0;
            srem_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        if (cmd.is_start)
                        begin
                            wp_reg       <= '0;
                            rp_reg       <= '0;
                            ended_reg    <= 1'b0;
                            started_reg  <= 1'b0;
                            expected_reg <= cmd.expected_bytes;
                            under_reg    <= '0;
                            prebuf_reg   <= '0;
                            speaking_reg <= 1'b1;
                        end
                        else if (cmd.is_feed)
                        begin
                            if (speaking_reg && !full)
                                wp_reg <= wp_inc;
                        end
                        else if (cmd.is_end)
                        begin
                            ended_reg <= 1'b1;
                        end
                        else
                        begin
                            out_reg.sample      <= '0;
                            out_reg.last        <= 1'b1;
                            out_reg.level       <= level_reg;
                            out_reg.underruns   <= under_reg;
                            out_reg.prebuffered <= prebuf_reg;
                            if (!speaking_reg)
                            begin
                                started_reg   <= 1'b0;
                                out_reg.kind  <= KIND_IDLE;
                                out_valid_reg <= 1'b1;
                            end
                            else if (wait_pb)
                            begin
                                out_reg.kind  <= KIND_PREBUF;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                started_reg         <= 1'b1;
                                prebuf_reg          <= pre_next;
                                out_reg.prebuffered <= pre_next;
                                if (avail == '0)
                                begin
                                    out_valid_reg <= 1'b1;
                                    if (ended_reg)
                                    begin
                                        speaking_reg  <= 1'b0;
                                        level_reg     <= '0;
                                        out_reg.level <= '0;
                                        out_reg.kind  <= KIND_DONE;
                                    end
                                    else
                                    begin
                                        under_reg         <= under_inc;
                                        out_reg.underruns <= under_inc;
                                        out_reg.kind      <= KIND_UNDER;
                                    end
                                end
                                else
                                begin
                                    rp_reg <= rp_sum[AW-1:0];
                                    if (nsamp != '0)
                                    begin
                                        ptr_reg   <= rp_reg;
                                        start_reg <= rp_reg;
                                        nsamp_reg <= nsamp;
                                        cnt_reg   <= '0;
                                        sum_reg   <= '0;
                                        pass2_reg <= 1'b0;
                                        state_reg <= S_LO;
                                    end
                                end
                            end
                        end
                    end
                end
                S_LO:
                begin
                    ptr_reg   <= ptr_inc;
                    state_reg <= S_HI;
                end
                S_HI:
                begin
                    ptr_reg   <= ptr_inc;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (!pass2_reg)
                    begin
                        sum_reg <= sum_reg + SW'(prod_reg[32:0]);
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg + 1'b1 == nsamp_reg)
                        begin
                            dq_reg      <= sum_reg + SW'(prod_reg[32:0]);
                            drem_reg    <= '0;
                            divisor_reg <= nsamp_reg;
                            dcnt_reg    <= DCW'(SW);
                            div_lvl_reg <= 1'b0;
                            state_reg   <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_LO;
                        end
                    end
                    else if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.kind        <= KIND_SAMPLE;
                        out_reg.sample      <= scaled;
                        out_reg.last        <= (cnt_reg + 1'b1 == nsamp_reg);
                        out_reg.level       <= level_reg;
                        out_reg.underruns   <= under_reg;
                        out_reg.prebuffered <= prebuf_reg;
                        cnt_reg             <= cnt_reg + 1'b1;
                        state_reg <= (cnt_reg + 1'b1 == nsamp_reg) ? S_IDLE : S_LO;
                    end
                end
                S_DIV:
                begin
                    drem_reg <= dge ? DIVW'(dt - {1'b0, divisor_reg}) : dt[DIVW-1:0];
                    dq_reg   <= {dq_reg[SW-2:0], dge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCW'(1))
                    begin
                        rad_reg   <= {1'b0, dq_reg[29:0], dge, 2'b00};
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        dcnt_reg  <= DCW'(17);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    srem_reg <= sge ? 19'(st - strial) : st[18:0];
                    root_reg <= {root_reg[15:0], sge};
                    rad_reg  <= {rad_reg[31:0], 2'b00};
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCW'(1))
                        state_reg <= S_LVL;
                end
                default:
                begin
                    if (!div_lvl_reg)
                    begin
                        dq_reg      <= SW'(lvl_num);
                        div_lvl_reg <= 1'b1;
                    end
                    else
                    begin
                        level_reg <= (lvl_quo > 17'h0FFFF) ? 16'hFFFF : lvl_quo[15:0];
                        ptr_reg   <= start_reg;
                        cnt_reg   <= '0;
                        pass2_reg <= 1'b1;
                        state_reg <= S_LO;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/audio_playback_jitter_buffer_core.sv
// Top level of the audio playback jitter buffer: configuration registers and the two halves.
//
//  channel   direction  handshake            payload
//  in        request    in_valid/in_ready    in_data (in_item_t)
//  out       result     out_valid/out_ready  out_data (out_item_t)
//  cfg       write      cfg_we               cfg_index, cfg_data
//
// Start, feed and end requests are executed in the idle state of the execution half.
// A playing pull steps each sample twice through the load, multiply and add states, with
// the mean divide, root and level update between the passes; other pulls finish in idle.
// The ring memory port (one read per cycle) makes each sample's two bytes separate reads.
// Reset clears all control state; the ring needs no clearing pass.
// A full output register stalls pulls and samples; the two-entry queue buffers new requests.
module audio_playback_jitter_buffer_core
#(
    parameter int RING_DEPTH = ajb_pkg::DEF_RING_DEPTH,
    parameter int CHUNK_LEN  = ajb_pkg::DEF_CHUNK_LEN
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ajb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ajb_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ajb_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume  <= VOLUME_RST;
            cfg_reg.min_pre <= MIN_PRE_RST;
            cfg_reg.max_pre <= MAX_PRE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLUME:  cfg_reg.volume  <= cfg_data;
                CFG_MIN_PRE: cfg_reg.min_pre <= cfg_data;
                CFG_MAX_PRE: cfg_reg.max_pre <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    ajb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ajb_back
    #(
        .RING_DEPTH (RING_DEPTH),
        .CHUNK_LEN  (CHUNK_LEN)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
